@@ rtl/i2a_pkg.sv @@
`default_nettype none
package i2a_pkg;

    localparam int VALUE_W = 32;
    localparam int BCD_W   = 40;
    localparam int SH_W    = 44;
    localparam int CNT_W   = 4;
    localparam int BIT_CNT_W = 5;

    // radix codes on the action field
    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_OCT = 2'd1;

    // digit counts per radix
    localparam logic [CNT_W-1:0] DEC_DIGITS = 4'd10;
    localparam logic [CNT_W-1:0] OCT_DIGITS = 4'd11;
    localparam logic [CNT_W-1:0] HEX_DIGITS = 4'd8;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ALPHA  = 8'h57;  // 'a' - 10
    localparam logic [7:0] CH_MINUS  = 8'h2d;

    // load command from the top level to the character emitter
    typedef struct packed {
        logic [SH_W-1:0]  digits;  // MSB-aligned digit string
        logic [CNT_W-1:0] count;   // digits in the string
        logic             oct;     // 3-bit digits when set, else 4-bit
        logic             neg;     // emit '-' first
    } t_load;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] w;
        w = {4'b0000, d};
        glyph = (d < 4'd10) ? (CH_ZERO + w) : (CH_ALPHA + w);
    endfunction

endpackage
`default_nettype wire

@@ rtl/i2a_if.sv @@
`default_nettype none
interface i2a_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/integer_to_ascii_radix_top.sv @@
// Integer to ASCII formatter, decimal / octal / hex.
// i_in  : valid/ready item with action (0 signed decimal, 1 octal, 2 or 3 hex)
//         and a 32-bit value.
// o_out : valid/ready stream of ASCII characters, most significant first,
//         last set on the final character of each run (1 to 11 characters).
// Decimal goes through a bit-serial double-dabble converter, one binary bit
// per cycle, and is then loaded into the emitter. The emitter then drops one
// leading zero per cycle and hands out one character per cycle while the
// receiver takes them. Octal/hex load into the emitter at the accept edge.
// One item is in flight at a time; i_in.ready rises once the last character
// sits in the output register, so the next item is taken while it waits.
// On a stall the output register holds; the emitter only skips leading zeros.
// Reset (synchronous, active low) empties the output register and drops any
// item in progress.
`default_nettype none
module integer_to_ascii_radix_top
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);

    logic               bcd_busy;
    logic               bcd_done;
    logic [BCD_W-1:0]   bcd;
    logic               emit_busy;
    logic               accept;
    logic               start_dec;
    logic               load;
    logic [VALUE_W-1:0] mag;
    t_load              cmd;
    logic               r_neg;

    // one item at a time: converter and emitter must both be free
    assign i_in.ready = !bcd_busy && !emit_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign start_dec  = accept && (i_in.action == MODE_DEC);
    assign load       = (accept && !start_dec) || bcd_done;

    // decimal magnitude; 0x80000000 maps onto itself, which is right unsigned
    assign mag = i_in.value[VALUE_W-1] ? (~i_in.value + VALUE_W'(1)) : i_in.value;

    always_ff @(posedge i_clk) begin
        if (start_dec) begin
            r_neg <= i_in.value[VALUE_W-1];
        end
    end

    // digit string handed to the emitter, MSB-aligned
    always_comb begin
        if (bcd_done) begin
            cmd.digits = {bcd, 4'b0000};
            cmd.count  = DEC_DIGITS;
            cmd.oct    = 1'b0;
            cmd.neg    = r_neg;
        end else if (i_in.action == MODE_OCT) begin
            // 11 octal digits need 33 bits: pad one zero on top
            cmd.digits = {1'b0, i_in.value, 11'b0};
            cmd.count  = OCT_DIGITS;
            cmd.oct    = 1'b1;
            cmd.neg    = 1'b0;
        end else begin
            cmd.digits = {i_in.value, 12'b0};
            cmd.count  = HEX_DIGITS;
            cmd.oct    = 1'b0;
            cmd.neg    = 1'b0;
        end
    end

    i2a_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_dec),
        .i_mag   (mag),
        .o_busy  (bcd_busy),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    i2a_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_cmd   (cmd),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

@@ rtl/i2a_bcd.sv @@
`default_nettype none
module i2a_bcd
    import i2a_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [VALUE_W-1:0] i_mag,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [BCD_W-1:0]        o_bcd
);

    logic [VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [BCD_W-1:0]     adj;

    // add 3 to every digit of 5 or more, then shift in one binary bit
    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                       : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_mag;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + BIT_CNT_W'(1);
            if (r_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_busy = r_busy | r_done;
    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire

@@ rtl/i2a_emit.sv @@
`default_nettype none
module i2a_emit
    import i2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_load i_cmd,
    output logic       o_busy,
    i2a_out_if.source  o_out
);

    logic [SH_W-1:0]  r_sh, n_sh;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_oct, n_oct;
    logic             r_sign, n_sign;
    logic             r_lead, n_lead;
    logic             r_busy, n_busy;
    logic             r_ov, n_ov;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;

    logic [3:0]       digit;
    logic [SH_W-1:0]  shifted;
    logic             skip;
    logic             slot;

    always_comb begin
        digit   = r_oct ? {1'b0, r_sh[SH_W-1 -: 3]} : r_sh[SH_W-1 -: 4];
        shifted = r_oct ? {r_sh[SH_W-4:0], 3'b000} : {r_sh[SH_W-5:0], 4'b0000};
        // leading zero: drop it unless it is the only digit left
        skip    = r_busy && r_lead && (digit == 4'd0) && (r_cnt > 4'd1);
        slot    = !r_ov || o_out.ready;

        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_oct  = r_oct;
        n_sign = r_sign;
        n_lead = r_lead;
        n_busy = r_busy;
        n_ov   = r_ov && !o_out.ready;
        n_char = r_char;
        n_last = r_last;

        if (i_load) begin
            n_sh   = i_cmd.digits;
            n_cnt  = i_cmd.count;
            n_oct  = i_cmd.oct;
            n_sign = i_cmd.neg;
            n_lead = 1'b1;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_sign && slot) begin
                n_ov   = 1'b1;
                n_char = CH_MINUS;
                n_last = 1'b0;
                n_sign = 1'b0;
            end
            if (skip) begin
                n_sh  = shifted;
                n_cnt = r_cnt - 4'd1;
            end else if (!r_sign && slot) begin
                n_ov   = 1'b1;
                n_char = glyph(digit);
                n_last = (r_cnt == 4'd1);
                n_sh   = shifted;
                n_cnt  = r_cnt - 4'd1;
                n_lead = 1'b0;
                if (r_cnt == 4'd1) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_sign <= 1'b0;
            r_lead <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
            r_sign <= n_sign;
            r_lead <= n_lead;
            r_cnt  <= n_cnt;
        end
        r_sh   <= n_sh;
        r_oct  <= n_oct;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy          = r_busy;
    assign o_out.valid     = r_ov;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

endmodule
`default_nettype wire

@@ rtl/i2a_chk.sv @@
`default_nettype none
module i2a_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("stalled item changed");

    // one item in flight: no back-to-back accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_char >= 8'h30 && i_out_char <= 8'h39) ||
            (i_out_char >= 8'h61 && i_out_char <= 8'h66) ||
            (i_out_char == 8'h2d))
        else $error("illegal character");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == 8'h2d) |-> !i_out_last)
        else $error("run ends on sign");

endmodule

bind integer_to_ascii_radix_top i2a_chk u_i2a_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.character),
    .i_out_last  (o_out.last)
);
`default_nettype wire

@@ sim/integer_to_ascii_radix_checker.sv @@
`timescale 1ns / 1ps
module integer_to_ascii_radix_checker
    import i2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2a_in_if         i_in,
    i2a_out_if        i_out,
    output int        o_fail_count,
    output int        o_chars_waiting
);

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } ascii_char_t;

    ascii_char_t expected_chars[$];
    ascii_char_t want;
    int          mismatches = 0;

    // Expands one number into the characters it should produce.
    function automatic void format_number(input logic [1:0] radix, input logic [31:0] num);
        logic [3:0]  digit [12];
        int          n_digits;
        logic [31:0] mag;
        logic        negative;
        ascii_char_t c;
        n_digits = 0;
        negative = 1'b0;
        mag      = num;
        if (radix == MODE_DEC) begin
            // two's complement; the most negative value maps onto itself as unsigned
            negative = num[31];
            if (negative)
                mag = ~num + 32'd1;
            do begin
                digit[n_digits] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                n_digits++;
            end while (mag != 0);
        end else if (radix == MODE_OCT) begin
            do begin
                digit[n_digits] = {1'b0, mag[2:0]};
                mag = mag >> 3;
                n_digits++;
            end while (mag != 0);
        end else begin
            do begin
                digit[n_digits] = mag[3:0];
                mag = mag >> 4;
                n_digits++;
            end while (mag != 0);
        end
        if (negative) begin
            c.character = "-";
            c.last      = 1'b0;
            expected_chars.push_back(c);
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            c.character = (digit[k] < 4'd10) ? ("0" + 8'(digit[k]))
                                             : ("a" + 8'(digit[k]) - 8'd10);
            c.last      = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                format_number(i_in.action, i_in.value);
            if (i_out.valid && i_out.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("character: expected none, got %h", i_out.character);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out.character !== want.character) begin
                        $error("character: expected %h, got %h", want.character,
                               i_out.character);
                        mismatches++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, i_out.last);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count    <= mismatches;
        o_chars_waiting <= expected_chars.size();
    end

endmodule

@@ sim/integer_to_ascii_radix_top_test.sv @@
`timescale 1ns / 1ps
module integer_to_ascii_radix_top_test;
    import i2a_pkg::*;

    // hex has no name in the package; code 3 decodes as hex too
    localparam logic [1:0] MODE_HEX     = 2'd2;
    localparam logic [1:0] MODE_HEX_ALT = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   chars_waiting;
    int   burst_left;

    i2a_in_if  item_ch ();
    i2a_out_if char_ch ();

    integer_to_ascii_radix_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_ch),
        .o_out   (char_ch)
    );

    // Watches both channels, predicts every character and counts mismatches.
    integer_to_ascii_radix_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in            (item_ch),
        .i_out           (char_ch),
        .o_fail_count    (fail_count),
        .o_chars_waiting (chars_waiting)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offers one item and holds it until the block takes it. Items go out in
    // bursts; when a burst runs out, valid drops for a random gap so that
    // idle cycles land on the converter, the digit skip and the emit phases.
    // The fields carry junk while valid is low.
    task automatic offer(input logic [1:0] radix, input logic [31:0] num);
        int gap;
        item_ch.valid  <= 1'b1;
        item_ch.action <= radix;
        item_ch.value  <= num;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            item_ch.valid  <= 1'b0;
            item_ch.action <= 2'($urandom);
            item_ch.value  <= $urandom;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    // Receiver: stretches of steady accept, random accept and a fixed duty
    // pattern. The third stretch is a long hold-off while the sender keeps
    // offering, so the output register fills and the input side backs up.
    initial begin
        int         stretch;
        int         span;
        int         style;
        int         period;
        int         duty;
        int         tick;
        char_ch.ready = 1'b0;
        stretch = 0;
        tick    = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (stretch == 2) begin
                repeat (400) begin
                    char_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end else begin
                span   = $urandom_range(20, 120);
                style  = $urandom_range(0, 2);
                period = $urandom_range(2, 8);
                duty   = $urandom_range(1, period - 1);
                repeat (span) begin
                    case (style)
                        0: char_ch.ready <= 1'b1;
                        1: char_ch.ready <= ($urandom_range(0, 2) == 0);
                        default: char_ch.ready <= ((tick % period) < duty);
                    endcase
                    tick++;
                    @(posedge clk);
                end
            end
            stretch++;
        end
    end

    initial begin
        logic [31:0] num;
        logic [31:0] tens;
        logic [1:0]  radix;
        int          waited;
        rst_n          = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.action = MODE_DEC;
        item_ch.value  = '0;
        burst_left     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in every radix, including the alternate hex code
        offer(MODE_DEC, 32'd0);
        offer(MODE_OCT, 32'd0);
        offer(MODE_HEX, 32'd0);
        offer(MODE_HEX_ALT, 32'd0);
        // decimal extremes: most negative, most positive, -1, ten-digit values, digit-count edges
        offer(MODE_DEC, 32'h8000_0000);
        offer(MODE_DEC, 32'h7fff_ffff);
        offer(MODE_DEC, 32'hffff_ffff);
        offer(MODE_DEC, 32'd1000000000);
        offer(MODE_DEC, 32'd0 - 32'd1000000000);
        offer(MODE_DEC, 32'd999999999);
        offer(MODE_DEC, 32'd9);
        offer(MODE_DEC, 32'd10);
        // octal: full 11-digit run, top digit alone, digit rollover
        offer(MODE_OCT, 32'hffff_ffff);
        offer(MODE_OCT, 32'o10000000000);
        offer(MODE_OCT, 32'o7);
        offer(MODE_OCT, 32'o10);
        offer(MODE_OCT, 32'h8000_0000);
        // hex: full run, lowercase letters, leading-zero edges
        offer(MODE_HEX, 32'hffff_ffff);
        offer(MODE_HEX, 32'h1000_0000);
        offer(MODE_HEX, 32'hf);
        offer(MODE_HEX, 32'h89ab_cdef);
        offer(MODE_HEX_ALT, 32'hdead_beef);
        offer(MODE_HEX_ALT, 32'h0123_4567);

        // random part: mostly values near digit-count boundaries, plus noise
        repeat (257) begin
            radix = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: num = $urandom;
                1: num = $urandom_range(0, 20);
                2: num = 32'd0 - 32'($urandom_range(1, 20));
                3: num = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
                4: begin
                    tens = 32'd1;
                    repeat ($urandom_range(0, 9)) tens = tens * 32'd10;
                    num = tens + 32'($urandom_range(0, 2)) - 32'd1;
                    if ($urandom_range(0, 1) == 1)
                        num = 32'd0 - num;
                end
                default: num = $urandom >> $urandom_range(0, 31);
            endcase
            offer(radix, num);
        end
        item_ch.valid <= 1'b0;

        // drain: wait for every predicted character, then a margin for strays
        @(posedge clk);
        waited = 0;
        while (chars_waiting != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (chars_waiting != 0)
            $error("characters: expected %0d more, got none", chars_waiting);

        if (fail_count == 0 && chars_waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i2a_pkg.sv
rtl/i2a_if.sv
rtl/i2a_bcd.sv
rtl/i2a_emit.sv
rtl/integer_to_ascii_radix_top.sv
rtl/i2a_chk.sv
sim/integer_to_ascii_radix_checker.sv
sim/integer_to_ascii_radix_top_test.sv
